[hdl/hrpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrpt_pkg
// Shared types and constants of the hex run-length palette thumbnail decoder.
// ----------------------------------------------------------------------------
package hrpt_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);
    localparam int COLOR_W     = 24;
    localparam int MAX_DESC    = 4;
    localparam int DESC_CNT_W  = $clog2(MAX_DESC + 1);

    localparam logic [7:0] ESC_BYTE = 8'hFD;
    localparam logic [7:0] HDR_CH0  = 8'h52;  // 'R'
    localparam logic [7:0] HDR_CH1  = 8'h4C;  // 'L'
    localparam logic [7:0] HDR_CH2  = 8'h45;  // 'E'

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PAL_SHORT = 2'd1,
        ST_ESC_CUT   = 2'd2
    } hrpt_status_t;

    // One pending result: palette index to look up, run length, end marker.
    typedef struct packed {
        logic [PAL_AW-1:0] idx;
        logic [7:0]        count;
        hrpt_status_t      status;
        logic              done;
    } hrpt_desc_t;

    typedef struct packed {
        logic       valid;
        hrpt_desc_t desc;
    } hrpt_head_t;

    typedef struct packed {
        logic               en;
        logic [PAL_AW-1:0]  addr;
        logic [COLOR_W-1:0] data;
    } hrpt_pal_wr_t;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
    } hrpt_pal_rd_t;

endpackage
`default_nettype wire

[hdl/hrpt_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrpt_if
// Valid/ready channels: hex characters in, colored runs out.
// ----------------------------------------------------------------------------
interface hrpt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface hrpt_run_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] run_count;
    logic [1:0] status;
    logic       done_res;

    modport source (output valid, output red, output green, output blue,
                    output run_count, output status, output done_res, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input run_count, input status, input done_res, output ready);
endinterface
`default_nettype wire

[hdl/hrpt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrpt_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module hrpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[hdl/hrpt_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrpt_decoder
// Hex parser, palette loader and run coder; queues up to four results a beat.
// ----------------------------------------------------------------------------
module hrpt_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    hrpt_char_if.sink             chars,
    input  logic                  pop,
    output hrpt_pkg::hrpt_head_t  head,
    output hrpt_pkg::hrpt_pal_wr_t pal_wr
);
    import hrpt_pkg::*;

    typedef enum logic [2:0] {
        PH_PAL,
        PH_HDR0,
        PH_HDR1,
        PH_HDR2,
        PH_DATA,
        PH_ESC1,
        PH_ESC2
    } phase_t;

    // {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    function automatic hrpt_desc_t mk_desc(input logic [7:0] idx, input logic [7:0] cnt,
                                           input hrpt_status_t st, input logic done);
        hrpt_desc_t d;
        d.idx    = idx;
        d.count  = cnt;
        d.status = st;
        d.done   = done;
        return d;
    endfunction

    phase_t            phase_reg, phase_next;
    logic [3:0]        nib_reg, nib_next;
    logic              held_reg, held_next;
    logic [PAL_AW-1:0] entry_reg, entry_next;
    logic [1:0]        sub_reg, sub_next;
    logic [7:0]        red_acc_reg, red_acc_next;
    logic [7:0]        green_acc_reg, green_acc_next;
    logic [7:0]        hdr_hi_reg, hdr_hi_next;
    logic [7:0]        hdr_lo_reg, hdr_lo_next;
    logic              rle_reg, rle_next;
    logic [7:0]        pend_reg, pend_next;

    hrpt_desc_t            desc_reg [MAX_DESC];
    hrpt_desc_t            desc_next [MAX_DESC];
    hrpt_desc_t            new_desc [MAX_DESC];
    logic [DESC_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DESC_CNT_W-1:0] new_cnt;

    logic       in_acc;
    logic [4:0] hx;
    logic       byte_ok;
    logic [7:0] byte_val;
    hrpt_status_t end_status;

    assign chars.ready = (cnt_reg == '0)
                      || (cnt_reg == DESC_CNT_W'(1) && pop && phase_reg != PH_PAL);
    assign in_acc      = chars.valid && chars.ready;

    assign head.valid = (cnt_reg != '0);
    assign head.desc  = desc_reg[0];

    // Stream decode of one beat.
    always_comb
    begin
        phase_next     = phase_reg;
        nib_next       = nib_reg;
        held_next      = held_reg;
        entry_next     = entry_reg;
        sub_next       = sub_reg;
        red_acc_next   = red_acc_reg;
        green_acc_next = green_acc_reg;
        hdr_hi_next    = hdr_hi_reg;
        hdr_lo_next    = hdr_lo_reg;
        rle_next       = rle_reg;
        pend_next      = pend_reg;
        pal_wr         = '0;
        new_cnt        = '0;
        end_status     = ST_OK;
        byte_ok        = 1'b0;
        for (int i = 0; i < MAX_DESC; i++)
        begin
            new_desc[i] = '0;
        end

        hx       = hex_decode(chars.ch);
        byte_val = {nib_reg, hx[3:0]};
        if (hx[4])
        begin
            if (held_reg)
            begin
                held_next = 1'b0;
                byte_ok   = 1'b1;
            end
            else
            begin
                nib_next  = hx[3:0];
                held_next = 1'b1;
            end
        end

        if (byte_ok)
        begin
            unique case (phase_reg)
                PH_PAL:
                begin
                    if (sub_reg == 2'd0)
                    begin
                        red_acc_next = byte_val;
                        sub_next     = 2'd1;
                    end
                    else if (sub_reg == 2'd1)
                    begin
                        green_acc_next = byte_val;
                        sub_next       = 2'd2;
                    end
                    else
                    begin
                        // Blue completes the entry: write all three bytes at once.
                        pal_wr.en   = 1'b1;
                        pal_wr.addr = entry_reg;
                        pal_wr.data = {red_acc_reg, green_acc_reg, byte_val};
                        sub_next    = 2'd0;
                        entry_next  = entry_reg + PAL_AW'(1);
                        if (entry_reg == PAL_AW'(PAL_ENTRIES - 1))
                        begin
                            phase_next = PH_HDR0;
                        end
                    end
                end
                PH_HDR0:
                begin
                    hdr_hi_next = byte_val;
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    hdr_lo_next = byte_val;
                    phase_next  = PH_HDR2;
                end
                PH_HDR2:
                begin
                    if (hdr_hi_reg == HDR_CH0 && hdr_lo_reg == HDR_CH1 && byte_val == HDR_CH2)
                    begin
                        rle_next = 1'b1;
                    end
                    else
                    begin
                        rle_next = 1'b0;
                        new_desc[0] = mk_desc(hdr_hi_reg, 8'd1, ST_OK, 1'b0);
                        new_desc[1] = mk_desc(hdr_lo_reg, 8'd1, ST_OK, 1'b0);
                        new_desc[2] = mk_desc(byte_val, 8'd1, ST_OK, 1'b0);
                        new_cnt     = DESC_CNT_W'(3);
                    end
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    if (rle_reg && byte_val == ESC_BYTE)
                    begin
                        phase_next = PH_ESC1;
                    end
                    else
                    begin
                        new_desc[0] = mk_desc(byte_val, 8'd1, ST_OK, 1'b0);
                        new_cnt     = DESC_CNT_W'(1);
                    end
                end
                PH_ESC1:
                begin
                    if (byte_val == ESC_BYTE)
                    begin
                        new_desc[0] = mk_desc(ESC_BYTE, 8'd1, ST_OK, 1'b0);
                        new_cnt     = DESC_CNT_W'(1);
                        phase_next  = PH_DATA;
                    end
                    else
                    begin
                        pend_next  = byte_val;
                        phase_next = PH_ESC2;
                    end
                end
                PH_ESC2:
                begin
                    // Zero-length run emits nothing.
                    if (pend_reg != 8'd0)
                    begin
                        new_desc[0] = mk_desc(byte_val, pend_reg, ST_OK, 1'b0);
                        new_cnt     = DESC_CNT_W'(1);
                    end
                    pend_next  = 8'd0;
                    phase_next = PH_DATA;
                end
                default:
                begin
                    phase_next = PH_PAL;
                end
            endcase
        end

        if (chars.last)
        begin
            // Flush a short header as plain pixels, then append the end result.
            if (phase_next == PH_PAL)
            begin
                end_status = ST_PAL_SHORT;
            end
            else if (phase_next == PH_ESC1 || phase_next == PH_ESC2)
            begin
                end_status = ST_ESC_CUT;
            end
            else if (phase_next == PH_HDR1)
            begin
                new_desc[new_cnt[1:0]] = mk_desc(hdr_hi_next, 8'd1, ST_OK, 1'b0);
                new_cnt = new_cnt + DESC_CNT_W'(1);
            end
            else if (phase_next == PH_HDR2)
            begin
                new_desc[new_cnt[1:0]] = mk_desc(hdr_hi_next, 8'd1, ST_OK, 1'b0);
                new_cnt = new_cnt + DESC_CNT_W'(1);
                new_desc[new_cnt[1:0]] = mk_desc(hdr_lo_next, 8'd1, ST_OK, 1'b0);
                new_cnt = new_cnt + DESC_CNT_W'(1);
            end
            new_desc[new_cnt[1:0]] = mk_desc(8'd0, 8'd0, end_status, 1'b1);
            new_cnt = new_cnt + DESC_CNT_W'(1);

            phase_next = PH_PAL;
            nib_next   = 4'd0;
            held_next  = 1'b0;
            entry_next = '0;
            sub_next   = 2'd0;
            rle_next   = 1'b0;
            pend_next  = 8'd0;
        end

        if (!in_acc)
        begin
            pal_wr.en = 1'b0;
        end
    end

    // Result queue: load on accept, shift on pop.
    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_DESC; i++)
        begin
            desc_next[i] = desc_reg[i];
        end
        if (in_acc)
        begin
            cnt_next = new_cnt;
            for (int i = 0; i < MAX_DESC; i++)
            begin
                desc_next[i] = new_desc[i];
            end
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - DESC_CNT_W'(1);
            for (int i = 0; i < MAX_DESC - 1; i++)
            begin
                desc_next[i] = desc_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PAL;
            nib_reg   <= 4'd0;
            held_reg  <= 1'b0;
            entry_reg <= '0;
            sub_reg   <= 2'd0;
            rle_reg   <= 1'b0;
            pend_reg  <= 8'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                phase_reg <= phase_next;
                nib_reg   <= nib_next;
                held_reg  <= held_next;
                entry_reg <= entry_next;
                sub_reg   <= sub_next;
                rle_reg   <= rle_next;
                pend_reg  <= pend_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            red_acc_reg   <= red_acc_next;
            green_acc_reg <= green_acc_next;
            hdr_hi_reg    <= hdr_hi_next;
            hdr_lo_reg    <= hdr_lo_next;
        end
        for (int i = 0; i < MAX_DESC; i++)
        begin
            desc_reg[i] <= desc_next[i];
        end
    end

endmodule
`default_nettype wire

[hdl/hrpt_emitter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrpt_emitter
// Palette lookup stage and output register for queued results.
// ----------------------------------------------------------------------------
module hrpt_emitter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hrpt_pkg::hrpt_head_t           head,
    output logic                           pop,
    output hrpt_pkg::hrpt_pal_rd_t         pal_rd,
    input  logic [hrpt_pkg::COLOR_W-1:0]   rd_data,
    hrpt_run_if.source                     runs
);
    import hrpt_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    hrpt_desc_t s1_desc_reg;
    logic       out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0] color;
    logic [7:0] red_reg, green_reg, blue_reg, count_reg;
    logic [1:0] status_reg;
    logic       done_reg;
    logic       s1_adv;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || runs.ready);
    assign pop    = head.valid && (!s1_valid_reg || s1_adv);

    assign pal_rd.en   = pop;
    assign pal_rd.addr = head.desc.idx;

    // End result carries no color.
    assign color = s1_desc_reg.done ? '0 : rd_data;

    always_comb
    begin
        s1_valid_next  = pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (runs.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_desc_reg <= head.desc;
        end
        if (s1_adv)
        begin
            red_reg    <= color[23:16];
            green_reg  <= color[15:8];
            blue_reg   <= color[7:0];
            count_reg  <= s1_desc_reg.count;
            status_reg <= 2'(s1_desc_reg.status);
            done_reg   <= s1_desc_reg.done;
        end
    end

    assign runs.valid     = out_valid_reg;
    assign runs.red       = red_reg;
    assign runs.green     = green_reg;
    assign runs.blue      = blue_reg;
    assign runs.run_count = count_reg;
    assign runs.status    = status_reg;
    assign runs.done_res  = done_reg;

endmodule
`default_nettype wire

[hdl/hex_rle_palette_thumbnail_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hex_rle_palette_thumbnail_decoder
// Hex text to palette-colored pixel runs, with optional run-length coding.
// ----------------------------------------------------------------------------
// Usage:
//   chars carries one ASCII character per beat plus a last flag on the final
//   character of a thumbnail. Non-hex characters are skipped; digit pairs form
//   bytes. The first 768 bytes load the 256-entry palette RAM; the rest become
//   runs on the runs channel (RGB, run_count, status, done_res).
//   The beat marked last produces one more result with done_res set and a
//   status: palette incomplete, truncated escape, or ok.
// Path: a result passes the queue, the lookup stage and the output register.
// Throughput: one beat per cycle while each beat yields at most one result and
//   runs is not stalled. A beat that yields several results holds chars until
//   its last result is looked up, since the single palette read port serves one
//   lookup per cycle. After a last beat, chars stays low until the queue is
//   empty, so the palette rewrite never overtakes the old stream's lookups.
// Reset: control state clears at once; the palette RAM is not cleared, and its
//   contents are only used after the current stream has rewritten all of it.
// Stall: runs is held in an output register; while the receiver stalls, one
//   more result waits in the lookup stage and the results of the last beat
//   (up to four) wait in the queue. chars drops ready as soon as the queue
//   cannot advance.
// ----------------------------------------------------------------------------
module hex_rle_palette_thumbnail_decoder (
    input  logic        clk,
    input  logic        rst_n,
    hrpt_char_if.sink   chars,
    hrpt_run_if.source  runs
);
    import hrpt_pkg::*;

    hrpt_head_t         head;
    hrpt_pal_wr_t       pal_wr;
    hrpt_pal_rd_t       pal_rd;
    logic               pop;
    logic [COLOR_W-1:0] rd_data;

    // Parse characters, load the palette, queue pending lookups.
    hrpt_decoder u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .pop    (pop),
        .head   (head),
        .pal_wr (pal_wr)
    );

    // Palette storage: one entry per index, red in the top byte.
    hrpt_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PAL_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (pal_wr.en),
        .waddr (pal_wr.addr),
        .wdata (pal_wr.data),
        .re    (pal_rd.en),
        .raddr (pal_rd.addr),
        .rdata (rd_data)
    );

    // Look up colors and hold each result beat until taken.
    hrpt_emitter u_emitter (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .pal_rd  (pal_rd),
        .rd_data (rd_data),
        .runs    (runs)
    );

endmodule
`default_nettype wire

[hdl/hrpt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrpt_checker
// Port-level checks on the result channel of the thumbnail decoder.
// ----------------------------------------------------------------------------
module hrpt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic [7:0] run_count,
    input logic [1:0] status,
    input logic       done_res
);

    // End result carries no color and no pixels.
    a_end_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> run_count == 8'd0 && red == 8'd0
                                  && green == 8'd0 && blue == 8'd0)
        else $error("end result carries color or pixels");

    // Run results have pixels and report ok.
    a_run_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> run_count != 8'd0 && status == 2'd0)
        else $error("run result with zero count or nonzero status");

    // Stalled beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({red, green, blue, run_count, status, done_res}))
        else $error("stalled result beat changed");

endmodule

bind hex_rle_palette_thumbnail_decoder hrpt_checker u_hrpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (runs.valid),
    .out_ready (runs.ready),
    .red       (runs.red),
    .green     (runs.green),
    .blue      (runs.blue),
    .run_count (runs.run_count),
    .status    (runs.status),
    .done_res  (runs.done_res)
);
`default_nettype wire
